>>> sv/stack_with_bidirectional_search_macros.svh
// Assertion helpers for the stack RTL.
`ifndef STACK_WITH_BIDIRECTIONAL_SEARCH_MACROS_SVH
`define STACK_WITH_BIDIRECTIONAL_SEARCH_MACROS_SVH

// Clocked property, disabled while reset is asserted.
`define SWBS_ASSERT(name, clk, rst_n, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Condition that must never be true outside reset.
`define SWBS_ASSERT_NEVER(name, clk, rst_n, cond, msg) \
  name: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

>>> sv/swbs_pkg.sv
package swbs_pkg;

  // Storage geometry
  localparam int unsigned CAPACITY = 16384;
  localparam int unsigned ADDR_W   = $clog2(CAPACITY);
  localparam int unsigned CNT_W    = ADDR_W + 1;

  // Fixed field widths
  localparam int unsigned DATA_W = 32;
  localparam int unsigned POS_W  = 14;

  typedef enum logic [1:0] {
    ACT_PUSH = 2'd0,
    ACT_POP  = 2'd1,
    ACT_FWD  = 2'd2,
    ACT_BWD  = 2'd3
  } action_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE   = 4'b0001,
    S_POP    = 4'b0010,
    S_SEARCH = 4'b0100,
    S_DONE   = 4'b1000
  } state_e;

  // Per-transaction result fields that do not come from the stack state
  typedef struct packed {
    logic [DATA_W-1:0] popped;
    logic              found;
    logic [POS_W-1:0]  position;
    status_e           status;
  } res_t;

endpackage

>>> sv/stack_with_bidirectional_search.sv
// Push and pop go from idle straight to done, but a pop that leaves entries first reads back
// the new top in the pop state; a search that misses the top walks the RAM in the search state.
// One transaction in flight: the next is taken the cycle after the result is
// registered; a search reads one entry per cycle from the RAM.
// Reset (async, active low) empties the stack; the RAM is not cleared, entries above
// the count are never read.
`include "stack_with_bidirectional_search_macros.svh"

module stack_with_bidirectional_search
  import swbs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  output logic                     in_stall_o,
  input  logic [1:0]               action_i,
  input  logic signed [DATA_W-1:0] operand_value_i,
  output logic                     out_valid_o,
  input  logic                     out_stall_i,
  output logic signed [DATA_W-1:0] popped_value_o,
  output logic                     found_o,
  output logic [POS_W-1:0]         position_o,
  output logic [1:0]               status_o,
  output logic signed [DATA_W-1:0] top_value_o,
  output logic                     not_empty_o,
  output logic [CNT_W-1:0]         entry_count_o
);

  state_e            state_q, state_d;
  logic [CNT_W-1:0]  count_q, count_d;
  logic [DATA_W-1:0] top_q, top_d;
  logic [DATA_W-1:0] key_q, key_d;
  logic              bwd_q, bwd_d;
  logic [CNT_W-1:0]  step_q, step_d;
  res_t              res_q, res_d;

  logic              we;
  logic [ADDR_W-1:0] waddr;
  logic [DATA_W-1:0] wdata;
  logic [ADDR_W-1:0] raddr;
  logic [DATA_W-1:0] rdata;

  logic              full, empty, out_free, load;
  logic [CNT_W-1:0]  cnt_m2, step_nxt, fwd_addr;

  // Entry storage
  swbs_ram #(
    .WIDTH (DATA_W),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (we),
    .waddr_i (waddr),
    .wdata_i (wdata),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign full     = (count_q == CNT_W'(CAPACITY));
  assign empty    = (count_q == '0);
  assign cnt_m2   = count_q - CNT_W'(2);
  assign step_nxt = step_q + CNT_W'(1);
  assign fwd_addr = count_q - CNT_W'(1) - step_nxt;
  assign out_free = !out_valid_o || !out_stall_i;
  assign load     = (state_q == S_DONE) && out_free;

  assign in_stall_o = (state_q != S_IDLE);

  // Sequencer: push/pop update, read-back of the new top, search walk
  always_comb begin
    state_d = state_q;
    count_d = count_q;
    top_d   = top_q;
    key_d   = key_q;
    bwd_d   = bwd_q;
    step_d  = step_q;
    res_d   = res_q;
    we      = 1'b0;
    waddr   = count_q[ADDR_W-1:0];
    wdata   = operand_value_i;
    raddr   = '0;

    unique case (state_q)
      S_IDLE: begin
        if (in_valid_i) begin
          res_d   = '{popped: '0, found: 1'b0, position: '0, status: ST_OK};
          key_d   = operand_value_i;
          bwd_d   = (action_e'(action_i) == ACT_BWD);
          step_d  = CNT_W'(1);
          state_d = S_DONE;
          unique case (action_e'(action_i))
            ACT_PUSH: begin
              if (full) begin
                res_d.status = ST_FULL;
              end else begin
                we      = 1'b1;
                top_d   = operand_value_i;
                count_d = count_q + CNT_W'(1);
              end
            end
            ACT_POP: begin
              if (empty) begin
                res_d.status = ST_EMPTY;
              end else begin
                res_d.popped = top_q;
                count_d      = count_q - CNT_W'(1);
                if (count_q > CNT_W'(1)) begin
                  raddr   = cnt_m2[ADDR_W-1:0];
                  state_d = S_POP;
                end
              end
            end
            ACT_FWD, ACT_BWD: begin
              // step 0 is the top, held in a register
              if (!empty) begin
                if (top_q == operand_value_i) begin
                  res_d.found = 1'b1;
                end else if (count_q != CNT_W'(1)) begin
                  raddr   = bwd_d ? '0 : cnt_m2[ADDR_W-1:0];
                  state_d = S_SEARCH;
                end
              end
            end
          endcase
        end
      end
      S_POP: begin
        top_d   = rdata;
        state_d = S_DONE;
      end
      S_SEARCH: begin
        // rdata holds the entry for step_q
        if (rdata == key_q) begin
          res_d.found    = 1'b1;
          res_d.position = step_q[POS_W-1:0];
          state_d        = S_DONE;
        end else if (step_nxt == count_q) begin
          state_d = S_DONE;
        end else begin
          raddr  = bwd_q ? step_q[ADDR_W-1:0] : fwd_addr[ADDR_W-1:0];
          step_d = step_nxt;
        end
      end
      S_DONE: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      count_q <= '0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
    end
  end

  // Working registers
  always_ff @(posedge clk_i) begin
    top_q  <= top_d;
    key_q  <= key_d;
    bwd_q  <= bwd_d;
    step_q <= step_d;
    res_q  <= res_d;
  end

  // Output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_o <= 1'b0;
    end else if (load) begin
      out_valid_o <= 1'b1;
    end else if (!out_stall_i) begin
      out_valid_o <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      popped_value_o <= res_q.popped;
      found_o        <= res_q.found;
      position_o     <= res_q.position;
      status_o       <= res_q.status;
      top_value_o    <= empty ? '0 : top_q;
      not_empty_o    <= !empty;
      entry_count_o  <= count_q;
    end
  end

  // Checks
  `SWBS_ASSERT_NEVER(a_count_bound, clk_i, rst_ni, count_q > CNT_W'(CAPACITY),
                     "entry count above capacity")
  `SWBS_ASSERT(a_push_grows, clk_i, rst_ni,
               in_valid_i && !in_stall_o && action_i == ACT_PUSH && !full
               |=> count_q == $past(count_q) + CNT_W'(1),
               "accepted push did not grow the stack")
  `SWBS_ASSERT(a_search_step, clk_i, rst_ni,
               state_q == S_SEARCH |-> step_q != '0 && step_q < count_q,
               "search step outside stored entries")
  `SWBS_ASSERT(a_done_holds, clk_i, rst_ni,
               state_q == S_DONE && out_valid_o && out_stall_i |=> state_q == S_DONE,
               "result dropped while output register busy")

endmodule

>>> sv/swbs_ram.sv
module swbs_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 16384,
  localparam int unsigned AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> tb/sv/stack_checker.sv
`timescale 1ns / 100ps

module stack_checker
  import swbs_pkg::*;
(
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  logic                     in_valid_i,
  input  logic                     in_stall_i,
  input  logic [1:0]               action_i,
  input  logic signed [DATA_W-1:0] operand_value_i,
  input  logic                     out_valid_i,
  input  logic                     out_stall_i,
  input  logic signed [DATA_W-1:0] popped_value_i,
  input  logic                     found_i,
  input  logic [POS_W-1:0]         position_i,
  input  logic [1:0]               status_i,
  input  logic signed [DATA_W-1:0] top_value_i,
  input  logic                     not_empty_i,
  input  logic [CNT_W-1:0]         entry_count_i,
  output int                       fail_count_o,
  output int                       pending_o,
  output int                       depth_o,
  output int                       checked_o,
  output int                       hits_o,
  output int                       refused_o,
  output int                       empty_pops_o
);

  typedef struct packed {
    logic [DATA_W-1:0] popped;
    logic              found;
    logic [POS_W-1:0]  position;
    status_e           status;
    logic [DATA_W-1:0] top;
    logic              not_empty;
    logic [CNT_W-1:0]  count;
  } stack_result_t;

  // Shadow copy of the stack
  logic [DATA_W-1:0] stack_mem [CAPACITY];
  int unsigned       depth;

  stack_result_t expected_results [$];
  int fail_count;
  int checked;
  int hits;
  int refused;
  int empty_pops;

  // Apply one transaction to the shadow stack, return what the block should report
  function automatic stack_result_t apply_stack_op(input logic [1:0] act,
                                                   input logic [DATA_W-1:0] key);
    stack_result_t r;
    int unsigned   step;
    int unsigned   idx;
    r = '0;
    case (act)
      ACT_PUSH: begin
        if (depth >= CAPACITY) begin
          r.status = ST_FULL;
        end else begin
          stack_mem[depth] = key;
          depth++;
        end
      end
      ACT_POP: begin
        if (depth == 0) begin
          r.status = ST_EMPTY;
        end else begin
          depth--;
          r.popped = stack_mem[depth];
        end
      end
      default: begin
        // top first, then toward the oldest (forward) or oldest upward (backward)
        for (step = 0; step < depth && !r.found; step++) begin
          if (step == 0) idx = depth - 1;
          else if (act == ACT_BWD) idx = step - 1;
          else idx = depth - 1 - step;
          if (stack_mem[idx] == key) begin
            r.found    = 1'b1;
            r.position = step[POS_W-1:0];
          end
        end
      end
    endcase
    r.not_empty = (depth != 0);
    r.top       = (depth != 0) ? stack_mem[depth-1] : '0;
    r.count     = depth[CNT_W-1:0];
    return r;
  endfunction

  task automatic compare_field(input string field, input logic [DATA_W-1:0] exp_v,
                               input logic [DATA_W-1:0] act_v);
    if (act_v !== exp_v) begin
      $error("%s: expected %h, actual %h", field, exp_v, act_v);
      fail_count++;
    end
  endtask

  // Watch both channels; results are checked before the new transaction is predicted
  always @(posedge clk_i or negedge rst_ni) begin
    stack_result_t want;
    if (!rst_ni) begin
      depth = 0;
      expected_results.delete();
      fail_count = 0;
      checked = 0;
      hits = 0;
      refused = 0;
      empty_pops = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (expected_results.size() == 0) begin
          $error("result transaction with nothing pending");
          fail_count++;
        end else begin
          want = expected_results.pop_front();
          compare_field("popped_value", want.popped, popped_value_i);
          compare_field("found", want.found, found_i);
          compare_field("position", want.position, position_i);
          compare_field("status", want.status, status_i);
          compare_field("top_value", want.top, top_value_i);
          compare_field("not_empty", want.not_empty, not_empty_i);
          compare_field("entry_count", want.count, entry_count_i);
          checked++;
          if (want.found) hits++;
          if (want.status == ST_FULL) refused++;
          if (want.status == ST_EMPTY) empty_pops++;
        end
      end
      if (in_valid_i && !in_stall_i) begin
        expected_results.push_back(apply_stack_op(action_i, operand_value_i));
      end
    end
    fail_count_o <= fail_count;
    pending_o    <= expected_results.size();
    depth_o      <= depth;
    checked_o    <= checked;
    hits_o       <= hits;
    refused_o    <= refused;
    empty_pops_o <= empty_pops;
  end

endmodule

>>> tb/sv/tb.sv
`timescale 1ns / 100ps

module tb;
  import swbs_pkg::*;

  localparam logic [DATA_W-1:0] FILL_TAG = 32'h5A5A_0000;
  localparam int RANDOM_ITEMS = 50;
  localparam int FILL_ITEMS   = 12;
  localparam int LONG_HOLD    = 64;

  logic                     clk;
  logic                     rst_n;
  logic                     in_valid;
  logic                     in_stall;
  action_e                  action;
  logic signed [DATA_W-1:0] operand_value;
  logic                     out_valid;
  logic                     out_stall;
  logic signed [DATA_W-1:0] popped_value;
  logic                     found;
  logic [POS_W-1:0]         position;
  logic [1:0]               status;
  logic signed [DATA_W-1:0] top_value;
  logic                     not_empty;
  logic [CNT_W-1:0]         entry_count;

  logic idle_en;
  logic hold_go;

  int fail_count;
  int pending;
  int depth;
  int checked;
  int hits;
  int refused;
  int empty_pops;

  logic [DATA_W-1:0] value_pool [8];

  stack_with_bidirectional_search dut (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_o     (in_stall),
    .action_i       (action),
    .operand_value_i(operand_value),
    .out_valid_o    (out_valid),
    .out_stall_i    (out_stall),
    .popped_value_o (popped_value),
    .found_o        (found),
    .position_o     (position),
    .status_o       (status),
    .top_value_o    (top_value),
    .not_empty_o    (not_empty),
    .entry_count_o  (entry_count)
  );

  stack_checker u_checker (
    .clk_i          (clk),
    .rst_ni         (rst_n),
    .in_valid_i     (in_valid),
    .in_stall_i     (in_stall),
    .action_i       (action),
    .operand_value_i(operand_value),
    .out_valid_i    (out_valid),
    .out_stall_i    (out_stall),
    .popped_value_i (popped_value),
    .found_i        (found),
    .position_i     (position),
    .status_i       (status),
    .top_value_i    (top_value),
    .not_empty_i    (not_empty),
    .entry_count_i  (entry_count),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .depth_o        (depth),
    .checked_o      (checked),
    .hits_o         (hits),
    .refused_o      (refused),
    .empty_pops_o   (empty_pops)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Run limit, several times the slowest legal run
  initial begin
    #5_000_000;
    $display("simulation failed");
    $finish;
  end

  // Receiver: random stall bursts, plus one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_stall <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_go && !hold_done) begin
        hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(posedge clk);
        out_stall <= 1'b0;
      end else if (idle_en && $urandom_range(0, 3) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 8)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one transaction and hold it until accepted, then maybe leave a gap
  task automatic send_item(input action_e act, input logic [DATA_W-1:0] val);
    in_valid      <= 1'b1;
    action        <= act;
    operand_value <= val;
    do @(posedge clk); while (in_stall);
    if (idle_en && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 8)) @(posedge clk);
    end
  endtask

  // Stop sending until every outstanding result has come back
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending != 0) @(posedge clk);
  endtask

  // Stimulus
  initial begin
    int      roll;
    int      n;
    action_e act;
    logic [DATA_W-1:0] val;

    rst_n         <= 1'b0;
    in_valid      <= 1'b0;
    action        <= ACT_PUSH;
    operand_value <= '0;
    idle_en       <= 1'b1;
    hold_go       <= 1'b0;
    value_pool[0] = 32'h8000_0000;
    value_pool[1] = 32'h7FFF_FFFF;
    value_pool[2] = 32'hFFFF_FFFF;
    value_pool[3] = 32'h0000_0000;
    for (int k = 4; k < 8; k++) value_pool[k] = $urandom();
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty store cases, extreme values, duplicates, both search orders
    send_item(ACT_POP, 32'h1234_5678);
    send_item(ACT_FWD, 32'h0000_0000);
    send_item(ACT_BWD, 32'hFFFF_FFFF);
    send_item(ACT_PUSH, 32'h8000_0000);
    send_item(ACT_PUSH, 32'h7FFF_FFFF);
    send_item(ACT_PUSH, 32'h0000_0000);
    send_item(ACT_PUSH, 32'hFFFF_FFFF);
    send_item(ACT_PUSH, 32'h7FFF_FFFF);
    send_item(ACT_PUSH, 32'h0000_0001);
    send_item(ACT_FWD, 32'h0000_0001);
    send_item(ACT_FWD, 32'h7FFF_FFFF);
    send_item(ACT_BWD, 32'h7FFF_FFFF);
    send_item(ACT_FWD, 32'h8000_0000);
    send_item(ACT_BWD, 32'h8000_0000);
    send_item(ACT_BWD, 32'hFFFF_FFFF);
    send_item(ACT_FWD, 32'h1234_5678);
    send_item(ACT_BWD, 32'h1234_5678);
    send_item(ACT_BWD, 32'h0000_0001);
    repeat (6) send_item(ACT_POP, $urandom());
    send_item(ACT_POP, $urandom());

    // Random: small stack, values mostly from a pool so searches hit
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i == 20) hold_go <= 1'b1;
      if (i == 35) wait_for_results();
      roll = $urandom_range(0, 99);
      if (depth > 20) roll = roll + 25;
      if (roll < 40) act = ACT_PUSH;
      else if (roll < 60) act = ACT_FWD;
      else if (roll < 80) act = ACT_BWD;
      else act = ACT_POP;
      val = ($urandom_range(0, 2) != 0) ? value_pool[$urandom_range(0, 7)] : $urandom();
      send_item(act, val);
    end

    // Final part, no idling: empty the stack, then build it up from distinct values
    idle_en <= 1'b0;
    wait_for_results();
    n = depth;
    repeat (n) send_item(ACT_POP, $urandom());
    for (int i = 0; i < FILL_ITEMS; i++) send_item(ACT_PUSH, FILL_TAG | i);

    // Deepest matches in both orders, full-length miss, then a shrunk stack
    send_item(ACT_FWD, FILL_TAG);
    send_item(ACT_BWD, FILL_TAG | (FILL_ITEMS - 2));
    send_item(ACT_BWD, FILL_TAG);
    send_item(ACT_FWD, 32'h0000_0000);
    repeat (3) send_item(ACT_POP, $urandom());
    send_item(ACT_PUSH, $urandom());
    send_item(ACT_FWD, FILL_TAG | (FILL_ITEMS - 4));

    wait_for_results();
    repeat (20) @(posedge clk);

    $display("Covered %0d transactions: %0d search hits, %0d pops on an empty stack,",
             checked, hits, empty_pops);
    $display("%0d pushes refused, a long output hold-off and a %0d-entry stack searched.",
             refused, FILL_ITEMS);
    if (fail_count == 0 && pending == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

>>> filelist.f
+incdir+sv
sv/swbs_pkg.sv
sv/swbs_ram.sv
sv/stack_with_bidirectional_search.sv
tb/sv/stack_checker.sv
tb/sv/tb.sv
